[sv/imu_cal_pkg.sv]
// ----------------------------------------------------------------------------
// imu_cal_pkg
// Shared widths, register indexes, types and helper functions of the IMU
// angle calibration and smoothing filter.
// ----------------------------------------------------------------------------
package imu_cal_pkg;

  localparam int ANGLE_W     = 16;
  localparam int DIFF_W      = ANGLE_W + 1;
  localparam int GAIN_W      = 16;
  localparam int FRAC_W      = GAIN_W;
  localparam int COUNT_W     = 16;
  localparam int SIGNS_W     = 3;
  localparam int ACC_W       = ANGLE_W + GAIN_W + 4;
  localparam int SHIFTED_W   = ACC_W - FRAC_W;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_INDEX_W-1:0] REG_USE_FIXED   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FIXED_PITCH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FIXED_ROLL  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CAL_SAMPLES = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_KEEP_GAIN   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_NEW_GAIN    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_AXIS_SIGNS  = 3'd6;

  localparam logic [COUNT_W-1:0] CAL_SAMPLES_RESET = 16'd1000;
  localparam logic [GAIN_W-1:0]  KEEP_GAIN_RESET   = 16'd58982;
  localparam logic [GAIN_W-1:0]  NEW_GAIN_RESET    = 16'd6554;

  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

  typedef struct packed {
    logic                       use_fixed;
    logic signed [ANGLE_W-1:0]  fixed_pitch;
    logic signed [ANGLE_W-1:0]  fixed_roll;
    logic [COUNT_W-1:0]         cal_samples;
    logic [GAIN_W-1:0]          keep_gain;
    logic [GAIN_W-1:0]          new_gain;
    logic [SIGNS_W-1:0]         axis_signs;
  } cfg_t;

  // One classified sample on its way from the front to the filter.
  typedef struct packed {
    logic                       calibrated;
    logic signed [DIFF_W-1:0]   diff_pitch;
    logic signed [DIFF_W-1:0]   diff_roll;
    logic signed [ANGLE_W-1:0]  yaw;
  } item_t;

  // Negation saturates the most negative angle to the largest positive one.
  function automatic logic signed [ANGLE_W-1:0] apply_sign(
      input logic signed [ANGLE_W-1:0] a, input logic neg);
    logic signed [ANGLE_W-1:0] r;
    r = a;
    if (neg) begin
      r = (a == ANGLE_MIN) ? ANGLE_MAX : -a;
    end
    return r;
  endfunction

  function automatic logic signed [ANGLE_W-1:0] sat_diff(
      input logic signed [DIFF_W-1:0] d);
    logic signed [ANGLE_W-1:0] r;
    r = d[ANGLE_W-1:0];
    if (d[DIFF_W-1] != d[DIFF_W-2]) begin
      r = d[DIFF_W-1] ? ANGLE_MIN : ANGLE_MAX;
    end
    return r;
  endfunction

  function automatic logic signed [ANGLE_W-1:0] sat_shifted(
      input logic [SHIFTED_W-1:0] v);
    logic signed [ANGLE_W-1:0] r;
    logic [SHIFTED_W-ANGLE_W:0] top;
    top = v[SHIFTED_W-1:ANGLE_W-1];
    r = v[ANGLE_W-1:0];
    if (!((&top) || !(|top))) begin
      r = v[SHIFTED_W-1] ? ANGLE_MIN : ANGLE_MAX;
    end
    return r;
  endfunction

endpackage

[sv/imu_cal_if.sv]
// ----------------------------------------------------------------------------
// imu_cal_if
// Valid/ready channels for IMU samples and filtered results.
// ----------------------------------------------------------------------------
interface imu_cal_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     sensor_ready;
  logic signed [imu_cal_pkg::ANGLE_W-1:0]   raw_pitch;
  logic signed [imu_cal_pkg::ANGLE_W-1:0]   raw_roll;
  logic signed [imu_cal_pkg::ANGLE_W-1:0]   raw_yaw;

  modport source (output valid, sensor_ready, raw_pitch, raw_roll, raw_yaw, input ready);
  modport sink   (input valid, sensor_ready, raw_pitch, raw_roll, raw_yaw, output ready);
endinterface

interface imu_cal_out_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     calibrated;
  logic signed [imu_cal_pkg::ANGLE_W-1:0]   out_pitch;
  logic signed [imu_cal_pkg::ANGLE_W-1:0]   out_roll;
  logic signed [imu_cal_pkg::ANGLE_W-1:0]   out_yaw;

  modport source (output valid, calibrated, out_pitch, out_roll, out_yaw, input ready);
  modport sink   (input valid, calibrated, out_pitch, out_roll, out_yaw, output ready);
endinterface

[sv/imu_cal_front.sv]
// ----------------------------------------------------------------------------
// imu_cal_front
// Accepts samples, applies the sign mask, runs the offset calibration and
// hands offset-corrected differences to the queue.
// ----------------------------------------------------------------------------
module imu_cal_front (
  input  logic                  clk,
  input  logic                  rst,
  input  imu_cal_pkg::cfg_t     cfg,
  imu_cal_in_if.sink            sample,
  input  logic                  full,
  output logic                  push,
  output imu_cal_pkg::item_t    push_item
);

  logic                                   running;
  logic [imu_cal_pkg::COUNT_W-1:0]        count;
  logic signed [imu_cal_pkg::ANGLE_W-1:0] pitch_off;
  logic signed [imu_cal_pkg::ANGLE_W-1:0] roll_off;

  logic signed [imu_cal_pkg::ANGLE_W-1:0] pitch_s;
  logic signed [imu_cal_pkg::ANGLE_W-1:0] roll_s;
  logic signed [imu_cal_pkg::ANGLE_W-1:0] yaw_s;
  logic signed [imu_cal_pkg::ANGLE_W-1:0] base_pitch;
  logic signed [imu_cal_pkg::ANGLE_W-1:0] base_roll;
  logic signed [imu_cal_pkg::DIFF_W-1:0]  sum_pitch;
  logic signed [imu_cal_pkg::DIFF_W-1:0]  sum_roll;
  logic [imu_cal_pkg::COUNT_W-1:0]        count_next;

  assign sample.ready = !full;
  assign push         = sample.valid && sample.ready;

  assign pitch_s = imu_cal_pkg::apply_sign(sample.raw_pitch, cfg.axis_signs[0]);
  assign roll_s  = imu_cal_pkg::apply_sign(sample.raw_roll,  cfg.axis_signs[1]);
  assign yaw_s   = imu_cal_pkg::apply_sign(sample.raw_yaw,   cfg.axis_signs[2]);

  // The first measured sample averages against the fixed offset register.
  assign base_pitch = (count == '0) ? cfg.fixed_pitch : pitch_off;
  assign base_roll  = (count == '0) ? cfg.fixed_roll  : roll_off;
  assign sum_pitch  = imu_cal_pkg::DIFF_W'(base_pitch) + imu_cal_pkg::DIFF_W'(pitch_s);
  assign sum_roll   = imu_cal_pkg::DIFF_W'(base_roll)  + imu_cal_pkg::DIFF_W'(roll_s);
  assign count_next = count + 1'b1;

  always_comb begin
    push_item = '0;
    if (running) begin
      push_item.calibrated = 1'b1;
      push_item.diff_pitch = imu_cal_pkg::DIFF_W'(pitch_s) - imu_cal_pkg::DIFF_W'(pitch_off);
      push_item.diff_roll  = imu_cal_pkg::DIFF_W'(roll_s)  - imu_cal_pkg::DIFF_W'(roll_off);
      push_item.yaw        = yaw_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      count   <= '0;
    end else if (push && !running && sample.sensor_ready) begin
      if (cfg.use_fixed) begin
        running <= 1'b1;
      end else begin
        count <= count_next;
        if (count_next >= cfg.cal_samples) begin
          running <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !running && sample.sensor_ready) begin
      if (cfg.use_fixed) begin
        pitch_off <= cfg.fixed_pitch;
        roll_off  <= cfg.fixed_roll;
      end else begin
        // Arithmetic shift of the sum gives the floor of the average.
        pitch_off <= sum_pitch[imu_cal_pkg::DIFF_W-1:1];
        roll_off  <= sum_roll[imu_cal_pkg::DIFF_W-1:1];
      end
    end
  end

endmodule

[sv/imu_cal_queue.sv]
// ----------------------------------------------------------------------------
// imu_cal_queue
// Short FIFO between the calibration front and the filter back end.
// ----------------------------------------------------------------------------
module imu_cal_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  imu_cal_pkg::item_t    push_item,
  input  logic                  pop,
  output imu_cal_pkg::item_t    head,
  output logic                  full,
  output logic                  empty
);

  imu_cal_pkg::item_t                   entries [imu_cal_pkg::QUEUE_DEPTH];
  logic [imu_cal_pkg::QUEUE_PTR_W-1:0]  wr_ptr;
  logic [imu_cal_pkg::QUEUE_PTR_W-1:0]  rd_ptr;
  logic [imu_cal_pkg::QUEUE_PTR_W:0]    count;

  assign full  = (count == (imu_cal_pkg::QUEUE_PTR_W+1)'(imu_cal_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + {{imu_cal_pkg::QUEUE_PTR_W{1'b0}}, push}
                     - {{imu_cal_pkg::QUEUE_PTR_W{1'b0}}, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
      count <= (imu_cal_pkg::QUEUE_PTR_W+1)'(imu_cal_pkg::QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
      !rst && $past(!rst) |-> count == $past(count)
        + {{imu_cal_pkg::QUEUE_PTR_W{1'b0}}, $past(push)}
        - {{imu_cal_pkg::QUEUE_PTR_W{1'b0}}, $past(pop)})
    else $error("queue fill count does not follow push and pop");

endmodule

[sv/imu_cal_back.sv]
// ----------------------------------------------------------------------------
// imu_cal_back
// Smoothing filter for pitch and roll with the result output register.
// ----------------------------------------------------------------------------
module imu_cal_back (
  input  logic                  clk,
  input  logic                  rst,
  input  imu_cal_pkg::cfg_t     cfg,
  input  logic                  empty,
  input  imu_cal_pkg::item_t    head,
  output logic                  pop,
  imu_cal_out_if.source         result
);

  logic                                   first_pending;
  logic signed [imu_cal_pkg::ANGLE_W-1:0] filt_pitch;
  logic signed [imu_cal_pkg::ANGLE_W-1:0] filt_roll;
  logic signed [imu_cal_pkg::ANGLE_W-1:0] pitch_next;
  logic signed [imu_cal_pkg::ANGLE_W-1:0] roll_next;
  logic                                   out_valid;

  // out = floor((keep*prev + new*diff + half) / 2^FRAC_W), saturated.
  function automatic logic signed [imu_cal_pkg::ANGLE_W-1:0] smooth(
      input logic [imu_cal_pkg::GAIN_W-1:0]         keep,
      input logic [imu_cal_pkg::GAIN_W-1:0]         gain,
      input logic signed [imu_cal_pkg::ANGLE_W-1:0] prev,
      input logic signed [imu_cal_pkg::DIFF_W-1:0]  diff);
    logic signed [imu_cal_pkg::GAIN_W:0]                       keep_s;
    logic signed [imu_cal_pkg::GAIN_W:0]                       gain_s;
    logic signed [imu_cal_pkg::GAIN_W+imu_cal_pkg::ANGLE_W:0]  prod_keep;
    logic signed [imu_cal_pkg::GAIN_W+imu_cal_pkg::DIFF_W:0]   prod_new;
    logic signed [imu_cal_pkg::ACC_W-1:0]                      acc;
    keep_s    = {1'b0, keep};
    gain_s    = {1'b0, gain};
    prod_keep = keep_s * prev;
    prod_new  = gain_s * diff;
    acc = imu_cal_pkg::ACC_W'(prod_keep) + imu_cal_pkg::ACC_W'(prod_new)
        + (imu_cal_pkg::ACC_W'(1) <<< (imu_cal_pkg::FRAC_W - 1));
    return imu_cal_pkg::sat_shifted(acc[imu_cal_pkg::ACC_W-1:imu_cal_pkg::FRAC_W]);
  endfunction

  assign pop          = !empty && (!out_valid || result.ready);
  assign result.valid = out_valid;

  always_comb begin
    if (first_pending) begin
      pitch_next = imu_cal_pkg::sat_diff(head.diff_pitch);
      roll_next  = imu_cal_pkg::sat_diff(head.diff_roll);
    end else begin
      pitch_next = smooth(cfg.keep_gain, cfg.new_gain, filt_pitch, head.diff_pitch);
      roll_next  = smooth(cfg.keep_gain, cfg.new_gain, filt_roll,  head.diff_roll);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      first_pending <= 1'b1;
      filt_pitch    <= '0;
      filt_roll     <= '0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (pop && head.calibrated) begin
        first_pending <= 1'b0;
        filt_pitch    <= pitch_next;
        filt_roll     <= roll_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.calibrated <= head.calibrated;
      result.out_pitch  <= head.calibrated ? pitch_next : '0;
      result.out_roll   <= head.calibrated ? roll_next  : '0;
      result.out_yaw    <= head.yaw;
    end
  end

endmodule

[sv/imu_angle_calibrate_filter_core.sv]
// ----------------------------------------------------------------------------
// imu_angle_calibrate_filter_core
// IMU angle offset calibration with first-order smoothing of pitch and roll.
// ----------------------------------------------------------------------------
// Samples enter on the sample channel and one result leaves on the result
// channel for every sample, in order; a transfer happens when valid and ready
// are both high. Configuration is written through cfg_write_en, cfg_index and
// cfg_data, by the user only while the block is idle; the block does not enforce it.
// While calibrating, each result has calibrated low and zero angles; ready
// samples move the offsets. Once running, pitch and roll are offset-corrected
// and smoothed, and yaw passes through with its sign applied.
// Each sample passes through the queue and then the result register before
// result valid rises. Throughput is one sample per cycle while the receiver
// does not stall, set by the filter feedback of one multiply-add per axis. A
// four-entry queue sits between the calibration front and the filter; the
// result register holds its data while the receiver stalls and the sample
// channel keeps taking data until the queue fills.
// A synchronous reset restores the register defaults, returns to calibrating
// and empties the queue and the result register.
// ----------------------------------------------------------------------------
module imu_angle_calibrate_filter_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [imu_cal_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [imu_cal_pkg::CFG_DATA_W-1:0]  cfg_data,
  imu_cal_in_if.sink                          sample,
  imu_cal_out_if.source                       result
);

  imu_cal_pkg::cfg_t   cfg;
  imu_cal_pkg::item_t  push_item;
  imu_cal_pkg::item_t  head;
  logic                push;
  logic                pop;
  logic                full;
  logic                empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.use_fixed   <= 1'b0;
      cfg.fixed_pitch <= '0;
      cfg.fixed_roll  <= '0;
      cfg.cal_samples <= imu_cal_pkg::CAL_SAMPLES_RESET;
      cfg.keep_gain   <= imu_cal_pkg::KEEP_GAIN_RESET;
      cfg.new_gain    <= imu_cal_pkg::NEW_GAIN_RESET;
      cfg.axis_signs  <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        imu_cal_pkg::REG_USE_FIXED:   cfg.use_fixed   <= cfg_data[0];
        imu_cal_pkg::REG_FIXED_PITCH: cfg.fixed_pitch <= cfg_data;
        imu_cal_pkg::REG_FIXED_ROLL:  cfg.fixed_roll  <= cfg_data;
        imu_cal_pkg::REG_CAL_SAMPLES: cfg.cal_samples <= cfg_data;
        imu_cal_pkg::REG_KEEP_GAIN:   cfg.keep_gain   <= cfg_data;
        imu_cal_pkg::REG_NEW_GAIN:    cfg.new_gain    <= cfg_data;
        imu_cal_pkg::REG_AXIS_SIGNS:  cfg.axis_signs  <= cfg_data[imu_cal_pkg::SIGNS_W-1:0];
        default: ;
      endcase
    end
  end

  imu_cal_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .sample    (sample),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  imu_cal_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  imu_cal_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .empty  (empty),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule

[bench/imu_angle_calibrate_filter_core_tb.sv]
// ----------------------------------------------------------------------------
// imu_angle_calibrate_filter_core_tb
// Self-checking bench for the IMU angle calibration and smoothing filter.
// A short calibration is run first. It ends either on the sample count or on
// a switch to fixed offsets, chosen at random. Filtered output is then checked
// over several gain and sign settings, including the extremes. Both channels
// stall at random, and every result is compared with a scoreboard that tracks
// offsets and filter state.
// ----------------------------------------------------------------------------
module imu_angle_calibrate_filter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 180;

  typedef struct packed {
    logic                                   calibrated;
    logic signed [imu_cal_pkg::ANGLE_W-1:0] pitch;
    logic signed [imu_cal_pkg::ANGLE_W-1:0] roll;
    logic signed [imu_cal_pkg::ANGLE_W-1:0] yaw;
  } angle_result_t;

  class angle_filter_scoreboard;
    logic                                   use_fixed;
    logic signed [imu_cal_pkg::ANGLE_W-1:0] fixed_pitch;
    logic signed [imu_cal_pkg::ANGLE_W-1:0] fixed_roll;
    logic [imu_cal_pkg::COUNT_W-1:0]        cal_samples;
    logic [imu_cal_pkg::GAIN_W-1:0]         keep_gain;
    logic [imu_cal_pkg::GAIN_W-1:0]         new_gain;
    logic [imu_cal_pkg::SIGNS_W-1:0]        axis_signs;

    bit          running;
    bit          first_pending;
    int unsigned cal_count;
    longint      pitch_off;
    longint      roll_off;
    longint      filt_pitch;
    longint      filt_roll;

    angle_result_t expected_angles[$];
    int            mismatches;

    function void restore();
      use_fixed     = 1'b0;
      fixed_pitch   = '0;
      fixed_roll    = '0;
      cal_samples   = imu_cal_pkg::CAL_SAMPLES_RESET;
      keep_gain     = imu_cal_pkg::KEEP_GAIN_RESET;
      new_gain      = imu_cal_pkg::NEW_GAIN_RESET;
      axis_signs    = '0;
      running       = 1'b0;
      first_pending = 1'b1;
      cal_count     = 0;
      pitch_off     = 0;
      roll_off      = 0;
      filt_pitch    = 0;
      filt_roll     = 0;
      mismatches    = 0;
      expected_angles.delete();
    endfunction

    function void set_reg(logic [imu_cal_pkg::CFG_INDEX_W-1:0] idx,
                          logic [imu_cal_pkg::CFG_DATA_W-1:0] v);
      case (idx)
        imu_cal_pkg::REG_USE_FIXED:   use_fixed   = v[0];
        imu_cal_pkg::REG_FIXED_PITCH: fixed_pitch = v[imu_cal_pkg::ANGLE_W-1:0];
        imu_cal_pkg::REG_FIXED_ROLL:  fixed_roll  = v[imu_cal_pkg::ANGLE_W-1:0];
        imu_cal_pkg::REG_CAL_SAMPLES: cal_samples = v[imu_cal_pkg::COUNT_W-1:0];
        imu_cal_pkg::REG_KEEP_GAIN:   keep_gain   = v[imu_cal_pkg::GAIN_W-1:0];
        imu_cal_pkg::REG_NEW_GAIN:    new_gain    = v[imu_cal_pkg::GAIN_W-1:0];
        imu_cal_pkg::REG_AXIS_SIGNS:  axis_signs  = v[imu_cal_pkg::SIGNS_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp_angle(longint v);
      longint hi;
      hi = (longint'(1) <<< (imu_cal_pkg::ANGLE_W - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function longint oriented(logic signed [imu_cal_pkg::ANGLE_W-1:0] raw, bit neg);
      longint a;
      a = raw;
      if (neg) a = clamp_angle(-a);
      return a;
    endfunction

    // Rounded Q0.16 blend of the previous output and the corrected sample.
    function longint smoothed(longint prev, longint diff);
      longint kg;
      longint ng;
      longint acc;
      kg  = keep_gain;
      ng  = new_gain;
      acc = kg * prev + ng * diff + (longint'(1) <<< (imu_cal_pkg::FRAC_W - 1));
      return clamp_angle(acc >>> imu_cal_pkg::FRAC_W);
    endfunction

    function void note_sample(logic rdy, logic signed [imu_cal_pkg::ANGLE_W-1:0] rp,
                              logic signed [imu_cal_pkg::ANGLE_W-1:0] rr,
                              logic signed [imu_cal_pkg::ANGLE_W-1:0] ry);
      longint p;
      longint r;
      longint y;
      longint bp;
      longint br;
      angle_result_t res;
      p   = oriented(rp, axis_signs[0]);
      r   = oriented(rr, axis_signs[1]);
      y   = oriented(ry, axis_signs[2]);
      res = '0;
      if (!running) begin
        if (rdy) begin
          if (use_fixed) begin
            pitch_off = fixed_pitch;
            roll_off  = fixed_roll;
            running   = 1'b1;
          end else begin
            // The running average starts from the fixed offset registers.
            bp = (cal_count == 0) ? longint'(fixed_pitch) : pitch_off;
            br = (cal_count == 0) ? longint'(fixed_roll) : roll_off;
            pitch_off = (bp + p) >>> 1;
            roll_off  = (br + r) >>> 1;
            cal_count = (cal_count + 1) & 32'hFFFF;
            if (cal_count >= cal_samples) running = 1'b1;
          end
        end
      end else begin
        if (first_pending) begin
          filt_pitch    = clamp_angle(p - pitch_off);
          filt_roll     = clamp_angle(r - roll_off);
          first_pending = 1'b0;
        end else begin
          filt_pitch = smoothed(filt_pitch, p - pitch_off);
          filt_roll  = smoothed(filt_roll, r - roll_off);
        end
        res.calibrated = 1'b1;
        res.pitch      = filt_pitch[imu_cal_pkg::ANGLE_W-1:0];
        res.roll       = filt_roll[imu_cal_pkg::ANGLE_W-1:0];
        res.yaw        = y[imu_cal_pkg::ANGLE_W-1:0];
      end
      expected_angles.push_back(res);
    endfunction

    function void compare(string field, logic signed [imu_cal_pkg::ANGLE_W-1:0] want,
                          logic signed [imu_cal_pkg::ANGLE_W-1:0] got);
      if (got !== want) begin
        mismatches++;
        $error("%s: expected %0d, got %0d", field, want, got);
      end
    endfunction

    function void check_result(angle_result_t got);
      angle_result_t want;
      if (expected_angles.size() == 0) begin
        mismatches++;
        $error("result transfer with no sample awaiting it");
        return;
      end
      want = expected_angles.pop_front();
      compare("calibrated", imu_cal_pkg::ANGLE_W'(want.calibrated),
              imu_cal_pkg::ANGLE_W'(got.calibrated));
      compare("out_pitch", want.pitch, got.pitch);
      compare("out_roll", want.roll, got.roll);
      compare("out_yaw", want.yaw, got.yaw);
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_write_en;
  logic [imu_cal_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [imu_cal_pkg::CFG_DATA_W-1:0]  cfg_data;

  imu_cal_in_if  sample();
  imu_cal_out_if result();

  imu_angle_calibrate_filter_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample       (sample),
    .result       (result)
  );

  angle_filter_scoreboard board = new;
  int gap_odds   = 0;
  int stall_left = 0;
  int cycles     = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Transfers on both channels are sampled here, before this edge's updates land.
  always @(posedge clk) begin
    if (!rst && sample.valid && sample.ready) begin
      board.note_sample(sample.sensor_ready, sample.raw_pitch, sample.raw_roll, sample.raw_yaw);
    end
    if (!rst && result.valid && result.ready) begin
      board.check_result(angle_result_t'({result.calibrated, result.out_pitch,
                                          result.out_roll, result.out_yaw}));
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      result.ready <= 1'b0;
    end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      stall_left   <= $urandom_range(0, 14);
      result.ready <= 1'b0;
    end else begin
      result.ready <= 1'b1;
    end
  end

  function automatic logic signed [imu_cal_pkg::ANGLE_W-1:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return imu_cal_pkg::ANGLE_MAX;
      1: return imu_cal_pkg::ANGLE_MIN;
      2: return imu_cal_pkg::ANGLE_W'(int'($urandom_range(0, 400)) - 200);
      default: return imu_cal_pkg::ANGLE_W'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [imu_cal_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [imu_cal_pkg::CFG_DATA_W-1:0] value);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= value;
    @(posedge clk);
    board.set_reg(idx, value);
  endtask

  task automatic set_filter(input logic [imu_cal_pkg::GAIN_W-1:0] keep,
                            input logic [imu_cal_pkg::GAIN_W-1:0] fresh,
                            input logic [imu_cal_pkg::SIGNS_W-1:0] signs);
    write_reg(imu_cal_pkg::REG_KEEP_GAIN, keep);
    write_reg(imu_cal_pkg::REG_NEW_GAIN, fresh);
    write_reg(imu_cal_pkg::REG_AXIS_SIGNS, imu_cal_pkg::CFG_DATA_W'(signs));
    cfg_write_en <= 1'b0;
  endtask

  // Valid stays high from one transfer into the next unless a gap is drawn.
  task automatic send_sample(input logic rdy,
                             input logic signed [imu_cal_pkg::ANGLE_W-1:0] p,
                             input logic signed [imu_cal_pkg::ANGLE_W-1:0] r,
                             input logic signed [imu_cal_pkg::ANGLE_W-1:0] y);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      sample.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    sample.valid        <= 1'b1;
    sample.sensor_ready <= rdy;
    sample.raw_pitch    <= p;
    sample.raw_roll     <= r;
    sample.raw_yaw      <= y;
    do @(posedge clk); while (!sample.ready);
  endtask

  task automatic wait_results_done();
    sample.valid <= 1'b0;
    do @(posedge clk); while (board.expected_angles.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    board.restore();
    cfg_write_en        = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    sample.valid        = 1'b0;
    sample.sensor_ready = 1'b0;
    sample.raw_pitch    = '0;
    sample.raw_roll     = '0;
    sample.raw_yaw      = '0;
    result.ready        = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Measured calibration from extreme start offsets with a count that cannot end.
    write_reg(imu_cal_pkg::REG_USE_FIXED, 16'd0);
    write_reg(imu_cal_pkg::REG_FIXED_PITCH, 16'h8000);
    write_reg(imu_cal_pkg::REG_FIXED_ROLL, 16'h7FFF);
    write_reg(imu_cal_pkg::REG_CAL_SAMPLES, 16'hFFFF);
    write_reg(imu_cal_pkg::REG_AXIS_SIGNS, 16'd5);
    cfg_write_en <= 1'b0;
    gap_odds = 4;
    send_sample(1'b0, imu_cal_pkg::ANGLE_MAX, imu_cal_pkg::ANGLE_MIN, 16'sd12345);
    send_sample(1'b1, imu_cal_pkg::ANGLE_MAX, imu_cal_pkg::ANGLE_MIN, imu_cal_pkg::ANGLE_MIN);
    send_sample(1'b1, imu_cal_pkg::ANGLE_MIN, imu_cal_pkg::ANGLE_MAX, imu_cal_pkg::ANGLE_MAX);
    send_sample(1'b1, 16'sd0, 16'sd0, 16'sd0);
    send_sample(1'b0, -16'sd1, -16'sd1, -16'sd1);
    send_sample(1'b1, -16'sd1, 16'sd1, -16'sd1);
    wait_results_done();

    // End calibration either by loading fixed offsets or by a reachable count.
    if ($urandom_range(0, 1) == 1) begin
      write_reg(imu_cal_pkg::REG_USE_FIXED, 16'd1);
      write_reg(imu_cal_pkg::REG_FIXED_PITCH, pick_angle());
      write_reg(imu_cal_pkg::REG_FIXED_ROLL, pick_angle());
    end else begin
      write_reg(imu_cal_pkg::REG_CAL_SAMPLES,
                imu_cal_pkg::CFG_DATA_W'($urandom_range(1, 7)));
    end
    write_reg(imu_cal_pkg::REG_AXIS_SIGNS, 16'd2);
    cfg_write_en <= 1'b0;
    send_sample(1'b0, 16'sd100, 16'sd100, 16'sd100);
    send_sample(1'b1, imu_cal_pkg::ANGLE_MAX, imu_cal_pkg::ANGLE_MAX, 16'sd1);
    send_sample(1'b1, imu_cal_pkg::ANGLE_MIN, imu_cal_pkg::ANGLE_MIN, -16'sd2);
    send_sample(1'b1, 16'sd5, -16'sd5, 16'sd0);
    send_sample(1'b1, 16'sd1, 16'sd1, 16'sd1);
    send_sample(1'b1, imu_cal_pkg::ANGLE_MAX, imu_cal_pkg::ANGLE_MIN, imu_cal_pkg::ANGLE_MIN);
    send_sample(1'b0, imu_cal_pkg::ANGLE_MIN, imu_cal_pkg::ANGLE_MAX, imu_cal_pkg::ANGLE_MAX);
    wait_results_done();

    // Gains summing to nearly two drive the filter into saturation.
    set_filter(16'hFFFF, 16'hFFFF, 3'd7);
    send_sample(1'b1, imu_cal_pkg::ANGLE_MAX, imu_cal_pkg::ANGLE_MAX, imu_cal_pkg::ANGLE_MAX);
    send_sample(1'b1, imu_cal_pkg::ANGLE_MAX, imu_cal_pkg::ANGLE_MAX, imu_cal_pkg::ANGLE_MIN);
    send_sample(1'b1, imu_cal_pkg::ANGLE_MIN, imu_cal_pkg::ANGLE_MIN, 16'sd0);
    send_sample(1'b0, imu_cal_pkg::ANGLE_MIN, imu_cal_pkg::ANGLE_MIN, -16'sd1);

    for (int phase = 0; phase < 8; phase++) begin
      wait_results_done();
      case (phase)
        0: set_filter(imu_cal_pkg::KEEP_GAIN_RESET, imu_cal_pkg::NEW_GAIN_RESET, 3'd0);
        1: set_filter(16'h0000, 16'h0000, 3'd1);
        2: set_filter(16'hFFFF, 16'hFFFF, 3'd2);
        3: set_filter(16'hFFFF, 16'h0000, 3'd3);
        4: set_filter(16'h0000, 16'hFFFF, 3'd4);
        5: set_filter(16'h8000, 16'h8000, 3'd5);
        6: set_filter(imu_cal_pkg::GAIN_W'($urandom), imu_cal_pkg::GAIN_W'($urandom), 3'd6);
        default: set_filter(imu_cal_pkg::GAIN_W'($urandom), imu_cal_pkg::GAIN_W'($urandom),
                            3'd7);
      endcase
      case (phase)
        0: gap_odds = 0;
        1: gap_odds = 3;
        2: gap_odds = 6;
        3: gap_odds = 2;
        4: gap_odds = 10;
        5: gap_odds = 4;
        6: gap_odds = 5;
        default: gap_odds = 0;
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Hold the sender once until the result side has fully caught up.
        if (phase == 2 && i == PHASE_ITEMS / 2) wait_results_done();
        send_sample($urandom_range(0, 3) != 0, pick_angle(), pick_angle(), pick_angle());
      end
    end

    wait_results_done();
    repeat (8) @(posedge clk);
    if (board.mismatches == 0 && board.expected_angles.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
sv/imu_cal_pkg.sv
sv/imu_cal_if.sv
sv/imu_cal_front.sv
sv/imu_cal_queue.sv
sv/imu_cal_back.sv
sv/imu_angle_calibrate_filter_core.sv
bench/imu_angle_calibrate_filter_core_tb.sv
